>>> design/aesks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesks_pkg
// Shared types, constants and byte functions for the AES-128 key schedule
// unit: S-box table, round constants and the SubWord/RotWord step.
// ----------------------------------------------------------------------------
package aesks_pkg;

	localparam int ROUND_W  = 4;
	localparam int HALF_W   = 64;
	localparam int KEY_W    = 128;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROUND  = 2'd1;

	localparam logic [ROUND_W-1:0] LAST_ROUND_RESET = 4'd10;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [31:0]        word_t;
	typedef logic [ROUND_W-1:0] round_t;

	// command from controller to datapath
	typedef struct packed {
		logic   load;        // capture the supplied key
		logic   step;        // replace the working key by the next one
		logic   from_start;  // step from the saved supplied key
		logic   backward;    // step down one round instead of up
		round_t rcon_round;  // round whose constant enters the step
	} dp_cmd_t;

	localparam logic [7:0] SBOX_TAB [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// round constant, zero for round 0 and above 10
	function automatic logic [7:0] rcon(input round_t rnd);
		logic [7:0] r;
		unique case (rnd)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// SubWord(RotWord(w)) xor Rcon; byte 0 of a word sits in bits 7:0
	function automatic word_t sub_rot(input word_t w, input round_t rnd);
		word_t r;
		r = {SBOX_TAB[w[7:0]], SBOX_TAB[w[31:24]], SBOX_TAB[w[23:16]], SBOX_TAB[w[15:8]]};
		return r ^ {24'd0, rcon(rnd)};
	endfunction

endpackage

>>> design/aes128_bidirectional_key_schedule_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_bidirectional_key_schedule_unit
// Derives the AES-128 round keys below and above one supplied round key.
// The supplied key is offered in the cycle after its transfer; each
// further round key follows in the cycle after the previous one is taken.
// Each item gives s + 1 + max(e - s, 0) results; a new item is taken only
// after the run's last result is taken; the one round step unit is shared.
// Reset clears the sequencer and loads the register reset values; no sweep.
// ----------------------------------------------------------------------------
module aes128_bidirectional_key_schedule_unit #(
	parameter int ROUND_CAP = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [aesks_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aesks_pkg::ROUND_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [aesks_pkg::HALF_W-1:0]     start_key_low,
	input  logic [aesks_pkg::HALF_W-1:0]     start_key_high,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [aesks_pkg::ROUND_W-1:0]    round_number,
	output logic [aesks_pkg::HALF_W-1:0]     round_key_low,
	output logic [aesks_pkg::HALF_W-1:0]     round_key_high,
	output logic                             last
);

	aesks_pkg::dp_cmd_t cmd;

	// sequencer and handshake
	aesks_controller #(
		.ROUND_CAP(ROUND_CAP)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.round_number(round_number),
		.last        (last),
		.cmd         (cmd)
	);

	// key registers and step unit
	aesks_datapath u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.start_key_low (start_key_low),
		.start_key_high(start_key_high),
		.round_key_low (round_key_low),
		.round_key_high(round_key_high)
	);

endmodule

>>> design/aesks_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesks_datapath
// Working key register, saved supplied key and the one-round step unit that
// derives the next lower or next higher round key.
// ----------------------------------------------------------------------------
module aesks_datapath (
	input  logic                     clk,
	input  aesks_pkg::dp_cmd_t       cmd,
	input  logic [aesks_pkg::HALF_W-1:0] start_key_low,
	input  logic [aesks_pkg::HALF_W-1:0] start_key_high,
	output logic [aesks_pkg::HALF_W-1:0] round_key_low,
	output logic [aesks_pkg::HALF_W-1:0] round_key_high
);

	aesks_pkg::key_t  key_q;
	aesks_pkg::key_t  start_key_q;
	aesks_pkg::key_t  src;
	aesks_pkg::key_t  next_key;
	aesks_pkg::word_t q0, q1, q2, q3;
	aesks_pkg::word_t p0, p1, p2, p3;

	// pick the source key and split it into words
	assign src = cmd.from_start ? start_key_q : key_q;
	assign q0  = src[31:0];
	assign q1  = src[63:32];
	assign q2  = src[95:64];
	assign q3  = src[127:96];

	// one round step, down or up
	always_comb begin
		if (cmd.backward) begin
			p3 = q3 ^ q2;
			p2 = q2 ^ q1;
			p1 = q1 ^ q0;
			p0 = q0 ^ aesks_pkg::sub_rot(p3, cmd.rcon_round);
		end else begin
			p0 = q0 ^ aesks_pkg::sub_rot(q3, cmd.rcon_round);
			p1 = q1 ^ p0;
			p2 = q2 ^ p1;
			p3 = q3 ^ p2;
		end
		next_key = {p3, p2, p1, p0};
	end

	// load the supplied key or advance the working key
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q       <= {start_key_high, start_key_low};
			start_key_q <= {start_key_high, start_key_low};
		end else if (cmd.step) begin
			key_q <= next_key;
		end
	end

	assign round_key_low  = key_q[63:0];
	assign round_key_high = key_q[127:64];

endmodule

>>> design/aesks_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesks_controller
// Configuration registers, run sequencer and output handshake: walks the
// rounds down to zero, then up to the last round, one per transfer.
// ----------------------------------------------------------------------------
module aesks_controller #(
	parameter int ROUND_CAP = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [aesks_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aesks_pkg::ROUND_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [aesks_pkg::ROUND_W-1:0]    round_number,
	output logic                             last,
	output aesks_pkg::dp_cmd_t               cmd
);

	localparam aesks_pkg::round_t MAX_R = aesks_pkg::round_t'(ROUND_CAP);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BACK = 2'd1;
	localparam logic [1:0] ST_FWD  = 2'd2;
	localparam logic [1:0] ST_LAST = 2'd3;

	logic [1:0]        state_q;
	aesks_pkg::round_t start_round_q, last_round_q;
	aesks_pkg::round_t s_cl, e_cl;
	aesks_pkg::round_t s_q, e_q;
	aesks_pkg::round_t round_q;
	aesks_pkg::round_t base, next_up, next_down;
	logic              valid_q, last_q;
	logic              accept, take, fwd_from_start;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_round_q <= '0;
			last_round_q  <= aesks_pkg::LAST_ROUND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == aesks_pkg::CFG_START_ROUND) start_round_q <= cfg_data;
			if (cfg_index == aesks_pkg::CFG_LAST_ROUND)  last_round_q  <= cfg_data;
		end
	end

	// clamp the configured rounds
	assign s_cl = (start_round_q > MAX_R) ? MAX_R : start_round_q;
	assign e_cl = (last_round_q  > MAX_R) ? MAX_R : last_round_q;

	assign accept = in_valid && !in_stall;
	assign take   = valid_q && !out_stall;

	// forward stepping restarts from the supplied key after the way down
	assign fwd_from_start = (round_q < s_q);
	assign base      = fwd_from_start ? s_q : round_q;
	assign next_up   = aesks_pkg::round_t'(base + 4'd1);
	assign next_down = aesks_pkg::round_t'(round_q - 4'd1);

	// datapath command
	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.step       = take && (state_q == ST_BACK || state_q == ST_FWD);
		cmd.backward   = (state_q == ST_BACK);
		cmd.from_start = (state_q == ST_FWD) && fwd_from_start;
		cmd.rcon_round = (state_q == ST_BACK) ? round_q : next_up;
	end

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			round_q <= '0;
			s_q     <= '0;
			e_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valid_q <= 1'b1;
						round_q <= s_cl;
						s_q     <= s_cl;
						e_q     <= e_cl;
						if (s_cl != '0) begin
							state_q <= ST_BACK;
							last_q  <= 1'b0;
						end else if (e_cl > s_cl) begin
							state_q <= ST_FWD;
							last_q  <= 1'b0;
						end else begin
							state_q <= ST_LAST;
							last_q  <= 1'b1;
						end
					end
				end
				ST_BACK: begin
					if (take) begin
						round_q <= next_down;
						if (next_down == '0) begin
							if (e_q > s_q) begin
								state_q <= ST_FWD;
							end else begin
								state_q <= ST_LAST;
								last_q  <= 1'b1;
							end
						end
					end
				end
				ST_FWD: begin
					if (take) begin
						round_q <= next_up;
						if (next_up == e_q) begin
							state_q <= ST_LAST;
							last_q  <= 1'b1;
						end
					end
				end
				ST_LAST: begin
					if (take) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b0;
						last_q  <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = valid_q;
	assign round_number = round_q;
	assign last         = last_q;

endmodule

>>> design/aesks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesks_checker
// Port-level checks on the key schedule unit, bound to the top level.
// ----------------------------------------------------------------------------
module aesks_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [aesks_pkg::ROUND_W-1:0]    round_number,
	input logic [aesks_pkg::HALF_W-1:0]     round_key_low,
	input logic [aesks_pkg::HALF_W-1:0]     round_key_high,
	input logic                             last
);

	// no new item while a run is still delivering
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

	// the supplied key shows up right after the transfer
	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("no result after input transfer");

	// a run does not end before its flagged result
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("run ended without final flag");

	// round numbers stay in range
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (round_number <= 4'd10))
		else $error("round number out of range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(round_number)
			&& $stable(round_key_low) && $stable(round_key_high) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind aes128_bidirectional_key_schedule_unit aesks_checker u_aesks_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.round_number  (round_number),
	.round_key_low (round_key_low),
	.round_key_high(round_key_high),
	.last          (last)
);
